[rtl/lpsa_pkg.sv]
// ----------------------------------------------------------------------------
// lpsa_pkg
// Shared types and constants of the LIFO page-stack allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package lpsa_pkg;

    localparam int PAGE_BYTES  = 4096;
    localparam int UNIT_BYTES  = 16;
    localparam int UNIT_SHIFT  = $clog2(UNIT_BYTES);
    localparam int PAGE_CAP    = 64;
    localparam int MAX_REQUEST = 512;

    localparam int STATUS_W = 2;
    localparam int LEN_W    = 10;
    localparam int OFFSET_W = 18;
    localparam int PAGES_W  = 7;
    localparam int START_W  = 14;
    localparam int UNITS_W  = 6;
    localparam int FREE_W   = 13;
    localparam int BYTES_W  = 10;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_MEM   = 2'd3;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [UNITS_W-1:0] units;
        logic [LEN_W-1:0]   length;
    } entry_t;

endpackage

`default_nettype wire

[rtl/lpsa_ram.sv]
// ----------------------------------------------------------------------------
// lpsa_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lpsa_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/lifo_page_stack_allocator_top.sv]
// Flow: the top entry is read at the request transfer edge, and the result is registered at
//   the end of the execute cycle and then offered.
// A new request is not taken during the execute cycle (entry read, then update and
//   write-back through the single entry RAM) nor while a waiting result is stalled.
// Reset: asynchronous, active low; clears stack depth, free bytes, pages held and the
//   result valid flag, and sets page_limit to 64. Entry RAM contents are not cleared.
// ----------------------------------------------------------------------------
// lifo_page_stack_allocator_top
// LIFO buffer allocator over a region grown and shrunk one page at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module lifo_page_stack_allocator_top #(
    parameter int MAX_ENTRIES = 256
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [lpsa_pkg::PAGES_W-1:0]   cfg_wr_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           mode,
    input  wire logic [lpsa_pkg::LEN_W-1:0]     request_length,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [lpsa_pkg::STATUS_W-1:0]  status,
    output logic      [lpsa_pkg::OFFSET_W-1:0]  payload_offset,
    output logic      [lpsa_pkg::LEN_W-1:0]     freed_length,
    output logic      [lpsa_pkg::PAGES_W-1:0]   pages_in_use
);

    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W = $clog2(MAX_ENTRIES);
    localparam int ENT_W  = $bits(lpsa_pkg::entry_t);
    localparam int SUM_W  = lpsa_pkg::FREE_W + 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                            state_reg, state_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [lpsa_pkg::FREE_W-1:0]     free_reg, free_next;
    logic [lpsa_pkg::PAGES_W-1:0]    pages_reg, pages_next;
    logic [lpsa_pkg::PAGES_W-1:0]    limit_reg;
    logic                            mode_reg;
    logic [lpsa_pkg::LEN_W-1:0]      len_reg;

    logic                            out_valid_reg, out_valid_next;
    logic [lpsa_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [lpsa_pkg::OFFSET_W-1:0]   offset_reg, offset_next;
    logic [lpsa_pkg::LEN_W-1:0]      freed_reg, freed_next;

    logic                            in_xfer;
    logic                            out_xfer;
    logic [CNT_W-1:0]                top_cnt;
    logic [ADDR_W-1:0]               top_idx;
    logic [ENT_W-1:0]                ram_rdata;
    lpsa_pkg::entry_t                rd_ent;
    lpsa_pkg::entry_t                wr_ent;
    logic                            ram_we;

    logic [lpsa_pkg::UNITS_W-1:0]    units;
    logic [lpsa_pkg::BYTES_W-1:0]    bytes;
    logic [lpsa_pkg::START_W-1:0]    start;
    logic [lpsa_pkg::START_W-1:0]    start_p1;
    logic [lpsa_pkg::PAGES_W-1:0]    limit;
    logic                            need_page;
    logic [SUM_W-1:0]                alloc_sum;
    logic [SUM_W-1:0]                free_sum;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);

    // top entry is read at the transfer edge, data arrives in ST_EXEC
    assign top_cnt = count_reg - CNT_W'(1);
    assign top_idx = top_cnt[ADDR_W-1:0];
    assign rd_ent  = lpsa_pkg::entry_t'(ram_rdata);

    lpsa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (wr_ent),
        .re    (in_xfer),
        .raddr (top_idx),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        units = lpsa_pkg::UNITS_W'((11'(len_reg) + 11'(lpsa_pkg::UNIT_BYTES - 1))
                >> lpsa_pkg::UNIT_SHIFT) + lpsa_pkg::UNITS_W'(1);
        bytes = lpsa_pkg::BYTES_W'(units) << lpsa_pkg::UNIT_SHIFT;
        if (count_reg == '0)
        begin
            start = '0;
        end
        else
        begin
            start = rd_ent.start + lpsa_pkg::START_W'(rd_ent.units);
        end
        start_p1  = start + lpsa_pkg::START_W'(1);
        limit     = (limit_reg < lpsa_pkg::PAGES_W'(lpsa_pkg::PAGE_CAP))
                    ? limit_reg : lpsa_pkg::PAGES_W'(lpsa_pkg::PAGE_CAP);
        need_page = free_reg < lpsa_pkg::FREE_W'(bytes);
        alloc_sum = SUM_W'(free_reg)
                    + (need_page ? SUM_W'(lpsa_pkg::PAGE_BYTES) : SUM_W'(0))
                    - SUM_W'(bytes);
        free_sum  = SUM_W'(free_reg)
                    + (SUM_W'(rd_ent.units) << lpsa_pkg::UNIT_SHIFT);

        wr_ent.start  = start;
        wr_ent.units  = units;
        wr_ent.length = len_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        free_next      = free_reg;
        pages_next     = pages_reg;
        out_valid_next = out_valid_reg && !out_xfer;
        status_next    = status_reg;
        offset_next    = offset_reg;
        freed_next     = freed_reg;
        ram_we         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
                status_next    = lpsa_pkg::ST_OK;
                offset_next    = '0;
                freed_next     = '0;
                if (mode_reg == lpsa_pkg::MODE_ALLOC)
                begin
                    if (len_reg > lpsa_pkg::LEN_W'(lpsa_pkg::MAX_REQUEST))
                    begin
                        status_next = lpsa_pkg::ST_TOO_LONG;
                    end
                    else if (count_reg >= CNT_W'(MAX_ENTRIES))
                    begin
                        status_next = lpsa_pkg::ST_NO_MEM;
                    end
                    else if (need_page && (pages_reg >= limit))
                    begin
                        status_next = lpsa_pkg::ST_NO_MEM;
                    end
                    else
                    begin
                        ram_we      = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                        free_next   = alloc_sum[lpsa_pkg::FREE_W-1:0];
                        pages_next  = pages_reg
                                      + (need_page ? lpsa_pkg::PAGES_W'(1)
                                                   : lpsa_pkg::PAGES_W'(0));
                        offset_next = lpsa_pkg::OFFSET_W'(start_p1) << lpsa_pkg::UNIT_SHIFT;
                    end
                end
                else
                begin
                    if (count_reg == '0)
                    begin
                        status_next = lpsa_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        count_next = top_cnt;
                        freed_next = rd_ent.length;
                        if ((free_sum >= SUM_W'(lpsa_pkg::PAGE_BYTES)) && (pages_reg != '0))
                        begin
                            free_next  = lpsa_pkg::FREE_W'(free_sum
                                         - SUM_W'(lpsa_pkg::PAGE_BYTES));
                            pages_next = pages_reg - lpsa_pkg::PAGES_W'(1);
                        end
                        else
                        begin
                            free_next = free_sum[lpsa_pkg::FREE_W-1:0];
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            free_reg      <= '0;
            pages_reg     <= '0;
            limit_reg     <= lpsa_pkg::PAGES_W'(lpsa_pkg::PAGE_CAP);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            free_reg      <= free_next;
            pages_reg     <= pages_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mode_reg <= mode;
            len_reg  <= request_length;
        end
        status_reg <= status_next;
        offset_reg <= offset_next;
        freed_reg  <= freed_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign payload_offset = offset_reg;
    assign freed_length   = freed_reg;
    assign pages_in_use   = pages_reg;

    // a result only appears out of the execute cycle
    a_out_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("result raised without execute cycle");

    // each transfer is followed directly by the execute state, in which no transfer is taken
    a_xfer_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_EXEC) && !in_xfer)
        else $error("transfer not followed by execute");

    // output register is free whenever a result is produced
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> !out_valid_reg)
        else $error("result overwritten");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("stack depth overflow");

    a_pages_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pages_reg <= lpsa_pkg::PAGES_W'(lpsa_pkg::PAGE_CAP))
        else $error("pages held above cap");

endmodule

`default_nettype wire

[bench/tb_lifo_page_stack_allocator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lifo_page_stack_allocator_top
// Self-checking bench for the LIFO page-stack allocator. A directed table
// covers the corner cases. Random phases then run under a range of page
// limits, including fills up to a full entry store and up to the page limit.
// An in-bench model of the stack predicts every result not given in the table.
// ----------------------------------------------------------------------------

module tb_lifo_page_stack_allocator_top;

    import lpsa_pkg::*;

    localparam int STORE_DEPTH      = 256;
    localparam int FILL_DEPTH       = STORE_DEPTH + 10;
    localparam int RANDOM_PER_PHASE = 120;
    localparam int NUM_PHASES       = 8;
    localparam int NUM_ROWS         = 25;
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int SETTLE_CYCLES    = 4;

    typedef struct packed {
        logic [STATUS_W-1:0] code;
        logic [OFFSET_W-1:0] offset;
        logic [LEN_W-1:0]    freed;
        logic [PAGES_W-1:0]  pages;
    } alloc_result_t;

    typedef struct packed {
        logic             op;
        logic [LEN_W-1:0] length;
        logic             typed;
        alloc_result_t    result;
    } stim_row_t;

    typedef enum int { FILL_NONE, FILL_TINY, FILL_BULK } fill_kind_e;

    localparam alloc_result_t UNTYPED = '0;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                cfg_wr_en      = 1'b0;
    logic [PAGES_W-1:0]  cfg_wr_data    = '0;
    logic                in_valid       = 1'b0;
    logic                in_stall;
    logic                req_mode       = MODE_ALLOC;
    logic [LEN_W-1:0]    req_length     = '0;
    logic                out_valid;
    logic                out_stall      = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] payload_offset;
    logic [LEN_W-1:0]    freed_length;
    logic [PAGES_W-1:0]  pages_in_use;

    // model state
    logic [START_W-1:0] buf_start [STORE_DEPTH];
    logic [UNITS_W-1:0] buf_units [STORE_DEPTH];
    logic [LEN_W-1:0]   buf_len   [STORE_DEPTH];
    int                 stack_depth  = 0;
    int                 spare_bytes  = 0;
    int                 pages_held_q = 0;
    int                 page_limit_q = 64;

    alloc_result_t outstanding_results [$];
    int            mismatch_count = 0;
    int            idle_cycles    = 0;
    int            stall_left     = 0;
    bit            no_idle        = 1'b0;

    stim_row_t directed_rows [NUM_ROWS] = '{
        {MODE_FREE,  10'd1023, 1'b1, ST_EMPTY,    18'd0,   10'd0,   7'd0},
        {MODE_ALLOC, 10'd0,    1'b1, ST_OK,       18'd16,  10'd0,   7'd1},
        {MODE_ALLOC, 10'd512,  1'b1, ST_OK,       18'd32,  10'd0,   7'd1},
        {MODE_ALLOC, 10'd513,  1'b1, ST_TOO_LONG, 18'd0,   10'd0,   7'd1},
        {MODE_ALLOC, 10'd1023, 1'b1, ST_TOO_LONG, 18'd0,   10'd0,   7'd1},
        {MODE_ALLOC, 10'd1,    1'b1, ST_OK,       18'd560, 10'd0,   7'd1},
        {MODE_FREE,  10'd0,    1'b1, ST_OK,       18'd0,   10'd1,   7'd1},
        {MODE_FREE,  10'd1023, 1'b1, ST_OK,       18'd0,   10'd512, 7'd1},
        // free bytes reach a whole page: it goes back
        {MODE_FREE,  10'd512,  1'b1, ST_OK,       18'd0,   10'd0,   7'd0},
        {MODE_FREE,  10'd0,    1'b1, ST_EMPTY,    18'd0,   10'd0,   7'd0},
        {MODE_ALLOC, 10'h155,  1'b0, UNTYPED},
        {MODE_ALLOC, 10'h2AA,  1'b1, ST_TOO_LONG, 18'd0,   10'd0,   7'd1},
        {MODE_ALLOC, 10'd16,   1'b0, UNTYPED},
        {MODE_ALLOC, 10'd17,   1'b0, UNTYPED},
        // eight full-size buffers run past the first page
        {MODE_ALLOC, 10'd512,  1'b0, UNTYPED},
        {MODE_ALLOC, 10'd512,  1'b0, UNTYPED},
        {MODE_ALLOC, 10'd512,  1'b0, UNTYPED},
        {MODE_ALLOC, 10'd512,  1'b0, UNTYPED},
        {MODE_ALLOC, 10'd512,  1'b0, UNTYPED},
        {MODE_ALLOC, 10'd512,  1'b0, UNTYPED},
        {MODE_ALLOC, 10'd512,  1'b0, UNTYPED},
        {MODE_ALLOC, 10'd512,  1'b0, UNTYPED},
        {MODE_FREE,  10'h155,  1'b0, UNTYPED},
        {MODE_FREE,  10'h2AA,  1'b0, UNTYPED},
        {MODE_FREE,  10'd0,    1'b0, UNTYPED}
    };

    // 0 and 127 lie outside the usual range; 127 is clamped by the page cap
    int         phase_limit [NUM_PHASES] = '{64, 1, 0, 127, 2, 20, 8, 64};
    fill_kind_e phase_fill  [NUM_PHASES] = '{FILL_TINY, FILL_NONE, FILL_NONE, FILL_NONE,
                                             FILL_NONE, FILL_BULK, FILL_NONE, FILL_NONE};
    logic [LEN_W-1:0] corner_lengths [9] = '{10'd0, 10'd1, 10'd15, 10'd16, 10'd17,
                                             10'd511, 10'd512, 10'd513, 10'd1023};

    lifo_page_stack_allocator_top #(
        .MAX_ENTRIES    (STORE_DEPTH)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (req_mode),
        .request_length (req_length),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .payload_offset (payload_offset),
        .freed_length   (freed_length),
        .pages_in_use   (pages_in_use)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic alloc_result_t allocator_step(logic op, logic [LEN_W-1:0] length);
        alloc_result_t r;
        int            units;
        int            bytes;
        int            cap;
        int            base;
        r = '0;
        if (op == MODE_ALLOC)
        begin
            if (length > MAX_REQUEST)
                r.code = ST_TOO_LONG;
            else if (stack_depth >= STORE_DEPTH)
                r.code = ST_NO_MEM;
            else
            begin
                units = (int'(length) + UNIT_BYTES - 1) / UNIT_BYTES + 1;
                bytes = units * UNIT_BYTES;
                cap   = (page_limit_q < PAGE_CAP) ? page_limit_q : PAGE_CAP;
                base  = 0;
                if (stack_depth > 0)
                    base = int'(buf_start[stack_depth-1]) + int'(buf_units[stack_depth-1]);
                if (spare_bytes < bytes && pages_held_q >= cap)
                    r.code = ST_NO_MEM;
                else
                begin
                    if (spare_bytes < bytes)
                    begin
                        pages_held_q++;
                        spare_bytes += PAGE_BYTES;
                    end
                    spare_bytes -= bytes;
                    buf_start[stack_depth] = START_W'(base);
                    buf_units[stack_depth] = UNITS_W'(units);
                    buf_len[stack_depth]   = length;
                    stack_depth++;
                    r.offset = OFFSET_W'((base + 1) * UNIT_BYTES);
                end
            end
        end
        else if (stack_depth == 0)
            r.code = ST_EMPTY;
        else
        begin
            stack_depth--;
            spare_bytes += int'(buf_units[stack_depth]) * UNIT_BYTES;
            r.freed = buf_len[stack_depth];
            if (spare_bytes >= PAGE_BYTES && pages_held_q > 0)
            begin
                pages_held_q--;
                spare_bytes -= PAGE_BYTES;
            end
        end
        r.pages = PAGES_W'(pages_held_q);
        return r;
    endfunction

    task automatic flag_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: mismatch: %s", $time, msg);
    endtask

    // Entered at a falling edge; returns at the falling edge after the transfer.
    task automatic send_request(logic op, logic [LEN_W-1:0] length, logic typed,
                                alloc_result_t typed_result);
        int            gap;
        alloc_result_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        req_mode   <= op;
        req_length <= length;
        do @(posedge clk); while (in_stall);
        predicted = allocator_step(op, length);
        outstanding_results.push_back(typed ? typed_result : predicted);
        @(negedge clk);
    endtask

    // Register writes only once every result is back and the pipe has settled.
    task automatic reprogram_page_limit(int value);
        in_valid <= 1'b0;
        while (outstanding_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= PAGES_W'(value);
        @(negedge clk);
        cfg_wr_en    <= 1'b0;
        page_limit_q = value & 'h7F;
    endtask

    // Result side: stall drawn afresh after each transfer
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            stall_left = no_idle ? 0 : $urandom_range(0, 10);
            if (outstanding_results.size() == 0)
                flag_mismatch($sformatf("result with no request outstanding (status %0d)",
                                        status));
            else
            begin
                want = outstanding_results.pop_front();
                if (status !== want.code)
                    flag_mismatch($sformatf("status: expected %0d, got %0d",
                                            want.code, status));
                if (payload_offset !== want.offset)
                    flag_mismatch($sformatf("payload_offset: expected %0d, got %0d",
                                            want.offset, payload_offset));
                if (freed_length !== want.freed)
                    flag_mismatch($sformatf("freed_length: expected %0d, got %0d",
                                            want.freed, freed_length));
                if (pages_in_use !== want.pages)
                    flag_mismatch($sformatf("pages_in_use: expected %0d, got %0d",
                                            want.pages, pages_in_use));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_lifo_page_stack_allocator_top NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        int               sent;
        int               burst;
        bit               grow;
        logic [LEN_W-1:0] length;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            if (i % 8 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            send_request(directed_rows[i].op, directed_rows[i].length,
                         directed_rows[i].typed, directed_rows[i].result);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            reprogram_page_limit(phase_limit[p]);

            // fill past the entry store or the page limit, then pop past empty
            if (phase_fill[p] != FILL_NONE)
            begin
                for (int k = 0; k < 2 * FILL_DEPTH; k++)
                begin
                    if (k % 50 == 0)
                        no_idle = ($urandom_range(0, 3) == 0);
                    if (k < FILL_DEPTH)
                        send_request(MODE_ALLOC, (phase_fill[p] == FILL_BULK)
                                     ? LEN_W'($urandom_range(400, 512))
                                     : LEN_W'($urandom_range(0, 32)), 1'b0, UNTYPED);
                    else
                        send_request(MODE_FREE, LEN_W'($urandom_range(0, 1023)), 1'b0,
                                     UNTYPED);
                end
            end

            sent = 0;
            while (sent < RANDOM_PER_PHASE)
            begin
                grow    = $urandom_range(0, 1);
                burst   = $urandom_range(1, 30);
                no_idle = ($urandom_range(0, 3) == 0);
                for (int k = 0; k < burst && sent < RANDOM_PER_PHASE; k++)
                begin
                    if ($urandom_range(0, 99) < (grow ? 80 : 25))
                    begin
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3: length = LEN_W'($urandom_range(0, 32));
                            4, 5, 6, 7: length = LEN_W'($urandom_range(0, MAX_REQUEST));
                            8:          length = LEN_W'($urandom_range(MAX_REQUEST + 1, 1023));
                            default:    length = corner_lengths[$urandom_range(0, 8)];
                        endcase
                        send_request(MODE_ALLOC, length, 1'b0, UNTYPED);
                    end
                    else
                        send_request(MODE_FREE, LEN_W'($urandom_range(0, 1023)), 1'b0,
                                     UNTYPED);
                    sent++;
                end
            end
        end

        in_valid <= 1'b0;
        while (outstanding_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_count == 0 && outstanding_results.size() == 0)
            $display("tb_lifo_page_stack_allocator_top OK");
        else
            $display("tb_lifo_page_stack_allocator_top NOT OK");
        $finish;
    end

endmodule
